>>> src/sgb_pkg.sv
// shared constants, types and tap weights of the separable gaussian blur
package sgb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int TAPS       = 17;
	localparam int HALF       = 8;
	localparam int DIM_W      = 12;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SLOT_W     = $clog2(TAPS);
	localparam int REG_IDX_W  = 2;
	localparam int PROD_W     = 15;
	localparam int PAIR_W     = 16;
	localparam int SUM_W      = 18;
	localparam int DIV_MUL_W  = 17;
	localparam int DIV_SHIFT  = 26;
	localparam int FLUSH_W    = 4;

	// reciprocal of 748 at 2^26, exact for sums below 2^18
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(89718);

	typedef logic [31:0] word_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_BORDER_RADIUS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              wr;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic              copy;
	} hctl_t;

	typedef struct packed {
		logic              emit;
		logic              last;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic              copy;
		logic [TAPS-1:0]   mask;
	} vctl_t;

	function automatic logic [6:0] tap_weight(input int t);
		int d;
		logic [6:0] w;
		d = t - HALF;
		if (d < 0) d = -d;
		unique case (d)
			0: w = 7'd80;
			1: w = 7'd77;
			2: w = 7'd70;
			3: w = 7'd59;
			4: w = 7'd46;
			5: w = 7'd34;
			6: w = 7'd24;
			7: w = 7'd15;
			8: w = 7'd9;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

endpackage

>>> src/sgb_if.sv
// request channels of the blur: pixel input, result output and register writes
interface sgb_pix_if;
	logic                valid;
	logic                ready;
	logic                kind;
	sgb_pkg::word_t      pixel_word;
	modport source (output valid, kind, pixel_word, input ready);
	modport sink (input valid, kind, pixel_word, output ready);
endinterface

interface sgb_res_if;
	logic                valid;
	logic                ready;
	sgb_pkg::word_t      blurred_word;
	logic                frame_last;
	modport source (output valid, blurred_word, frame_last, input ready);
	modport sink (input valid, blurred_word, frame_last, output ready);
endinterface

interface sgb_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sgb_pkg::REG_IDX_W-1:0]       index;
	logic [sgb_pkg::DIM_W-1:0]           data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/sgb_cell.sv
// one cell of the row window: a pixel and its in-row flag, passed to the next cell
module sgb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  logic           clr,
	input  sgb_pkg::word_t d_in,
	input  logic           v_in,
	output sgb_pkg::word_t d_out,
	output logic           v_out
);

	sgb_pkg::word_t data_q;
	logic           valid_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= v_in & ~clr;
		end
	end

	assign d_out = data_q;
	assign v_out = valid_q;

endmodule

>>> src/sgb_line_bank.sv
// one row of the blurred line store, one write and one registered read port
module sgb_line_bank #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/sgb_tap.sv
// 17-tap weighted sum per byte, divided by 748, with a copy bypass; three stages
module sgb_tap (
	input  logic                                   clk,
	input  logic                                   en,
	input  sgb_pkg::word_t [sgb_pkg::TAPS-1:0]     words,
	input  logic [sgb_pkg::TAPS-1:0]               mask,
	input  logic                                   copy,
	output sgb_pkg::word_t                         result
);

	localparam int NPAIR = (sgb_pkg::TAPS + 1) / 2;

	logic [sgb_pkg::PAIR_W-1:0]            pair_c [4][NPAIR];
	logic [sgb_pkg::PAIR_W-1:0]            pair_s1 [4][NPAIR];
	logic [sgb_pkg::SUM_W-1:0]             sum_c [4];
	logic [sgb_pkg::SUM_W-1:0]             sum_s2 [4];
	logic [sgb_pkg::SUM_W+sgb_pkg::DIV_MUL_W-1:0] prod_s3 [4];
	sgb_pkg::word_t                        center_s1, center_s2, center_s3;
	logic                                  copy_s1, copy_s2, copy_s3;

	always_comb begin
		logic [sgb_pkg::PROD_W-1:0] p [sgb_pkg::TAPS];
		for (int ch = 0; ch < 4; ch++) begin
			for (int t = 0; t < sgb_pkg::TAPS; t++) begin
				p[t] = mask[t] ? sgb_pkg::PROD_W'(words[t][8*ch +: 8]) *
					sgb_pkg::PROD_W'(sgb_pkg::tap_weight(t)) : '0;
			end
			for (int k = 0; k < NPAIR; k++) begin
				if (2*k+1 < sgb_pkg::TAPS) begin
					pair_c[ch][k] = sgb_pkg::PAIR_W'(p[2*k]) + sgb_pkg::PAIR_W'(p[2*k+1]);
				end else begin
					pair_c[ch][k] = sgb_pkg::PAIR_W'(p[2*k]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			sum_c[ch] = '0;
			for (int k = 0; k < NPAIR; k++) begin
				sum_c[ch] = sum_c[ch] + sgb_pkg::SUM_W'(pair_s1[ch][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1   <= pair_c;
			center_s1 <= words[sgb_pkg::HALF];
			copy_s1   <= copy;
			sum_s2    <= sum_c;
			center_s2 <= center_s1;
			copy_s2   <= copy_s1;
			for (int ch = 0; ch < 4; ch++) begin
				prod_s3[ch] <= (sgb_pkg::SUM_W+sgb_pkg::DIV_MUL_W)'(sum_s2[ch]) *
					(sgb_pkg::SUM_W+sgb_pkg::DIV_MUL_W)'(sgb_pkg::DIV_MUL);
			end
			center_s3 <= center_s2;
			copy_s3   <= copy_s2;
		end
	end

	always_comb begin
		if (copy_s3) begin
			result = center_s3;
		end else begin
			for (int ch = 0; ch < 4; ch++) begin
				result[8*ch +: 8] = prod_s3[ch][sgb_pkg::DIV_SHIFT +: 8];
			end
		end
	end

endmodule

>>> src/separable_gaussian_blur_17tap.sv
// top level of the separable 17-tap gaussian blur over a raster pixel stream
// results: each result follows the request that makes it ready through the vertical control
// pipeline and the output register, and waits for the tail flush when that request is a row's last pixel
// throughput: one request per cycle while results are not stalled; after each row's last pixel ready
// stays low while the row window shifts out the tail columns
// reset: asynchronous, clears registers to 640x480, radius 0, counters and window empty
module separable_gaussian_blur_17tap (
	input  logic        clk,
	input  logic        arst_n,
	sgb_pix_if.sink     pixels,
	sgb_res_if.source   results,
	sgb_cfg_if.sink     cfg
);

	localparam int CW    = sgb_pkg::DIM_W + 2;
	localparam int TAPS  = sgb_pkg::TAPS;
	localparam int HS    = 4;
	localparam int VS    = 10;

	logic [sgb_pkg::DIM_W-1:0]  fw_q, fh_q, rad_q, w_eff, h_eff;
	logic [sgb_pkg::DIM_W-1:0]  rr_q, rr_n;
	logic [sgb_pkg::COL_W-1:0]  rc_q, rc_n, ej_q;
	logic [sgb_pkg::ROW_W-1:0]  ei_q;
	logic [sgb_pkg::SLOT_W-1:0] ws_q, ws_n, es_q, fslot_q;
	logic [sgb_pkg::FLUSH_W-1:0] fl_cnt_q;
	logic [CW-1:0]              cf_q;

	logic adv, pix_acc, is_pix, row_end, flush_on, flush_tick, eval, out_ready, do_emit;
	logic last, cfg_hit, frame_rst, clr_row;
	logic [CW-1:0] nr, nc, e8, j8, hc;
	logic          hwr;

	sgb_pkg::hctl_t hctl_s [1:HS];
	sgb_pkg::vctl_t vctl_s [1:VS];
	sgb_pkg::hctl_t hctl_c;
	sgb_pkg::vctl_t vctl_c;

	sgb_pkg::word_t                 win_d [TAPS];
	logic [TAPS-1:0]                win_v;
	sgb_pkg::word_t [TAPS-1:0]      win_words;
	sgb_pkg::word_t [TAPS-1:0]      rot_s7;
	sgb_pkg::word_t                 rdata [TAPS];
	sgb_pkg::word_t                 hres, vres;
	sgb_pkg::word_t                 out_word_q;
	logic                           out_v_q, out_last_q;

	// effective frame size
	always_comb begin
		w_eff = fw_q;
		if (fw_q == '0) w_eff = sgb_pkg::DIM_W'(1);
		if (CW'(fw_q) > CW'(sgb_pkg::MAX_WIDTH)) w_eff = sgb_pkg::DIM_W'(sgb_pkg::MAX_WIDTH);
		h_eff = fh_q;
		if (fh_q == '0) h_eff = sgb_pkg::DIM_W'(1);
		if (CW'(fh_q) > CW'(sgb_pkg::MAX_HEIGHT)) h_eff = sgb_pkg::DIM_W'(sgb_pkg::MAX_HEIGHT);
	end

	assign adv           = !out_v_q || results.ready;
	assign flush_on      = fl_cnt_q != '0;
	assign pixels.ready  = adv && !flush_on;
	assign pix_acc       = pixels.valid && pixels.ready;
	assign is_pix        = pix_acc && !pixels.kind && (rr_q < h_eff);
	assign row_end       = is_pix && (CW'(rc_q) == CW'(w_eff) - CW'(1));
	assign flush_tick    = adv && flush_on;
	assign clr_row       = is_pix && (rc_q == '0);
	assign eval          = (pix_acc && !row_end) ||
		(flush_tick && fl_cnt_q == sgb_pkg::FLUSH_W'(1));
	assign cfg.ready     = 1'b1;

	always_comb begin
		rr_n = rr_q;
		rc_n = rc_q;
		ws_n = ws_q;
		if (is_pix) begin
			if (row_end) begin
				rc_n = '0;
				rr_n = rr_q + 1'b1;
				ws_n = (ws_q == sgb_pkg::SLOT_W'(TAPS-1)) ? '0 : ws_q + 1'b1;
			end else begin
				rc_n = rc_q + 1'b1;
			end
		end
	end

	// readiness of the next output
	always_comb begin
		e8 = CW'(ei_q) + CW'(sgb_pkg::HALF);
		j8 = CW'(ej_q) + CW'(sgb_pkg::HALF);
		nr = (e8 < CW'(h_eff)) ? e8 : CW'(h_eff) - CW'(1);
		nc = (j8 < CW'(w_eff)) ? j8 : CW'(w_eff) - CW'(1);
		out_ready = (CW'(rr_n) > nr) || ((CW'(rr_n) == nr) && (CW'(rc_n) > nc));
		do_emit   = eval && out_ready;
		last      = do_emit && (CW'(ei_q) == CW'(h_eff) - CW'(1)) &&
			(CW'(ej_q) == CW'(w_eff) - CW'(1));
	end

	always_comb begin
		cfg_hit = 1'b0;
		if (cfg.valid && cfg.ready) begin
			unique case (sgb_pkg::reg_idx_t'(cfg.index))
				sgb_pkg::REG_FRAME_WIDTH,
				sgb_pkg::REG_FRAME_HEIGHT,
				sgb_pkg::REG_BORDER_RADIUS: cfg_hit = 1'b1;
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	assign frame_rst = last || cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= sgb_pkg::DIM_W'(640);
			fh_q  <= sgb_pkg::DIM_W'(480);
			rad_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (sgb_pkg::reg_idx_t'(cfg.index))
				sgb_pkg::REG_FRAME_WIDTH:   fw_q  <= cfg.data;
				sgb_pkg::REG_FRAME_HEIGHT:  fh_q  <= cfg.data;
				sgb_pkg::REG_BORDER_RADIUS: rad_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
			rc_q <= '0;
			ws_q <= '0;
			ei_q <= '0;
			ej_q <= '0;
			es_q <= '0;
		end else if (frame_rst) begin
			rr_q <= '0;
			rc_q <= '0;
			ws_q <= '0;
			ei_q <= '0;
			ej_q <= '0;
			es_q <= '0;
		end else begin
			rr_q <= rr_n;
			rc_q <= rc_n;
			ws_q <= ws_n;
			if (do_emit) begin
				if (CW'(ej_q) == CW'(w_eff) - CW'(1)) begin
					ej_q <= '0;
					ei_q <= ei_q + 1'b1;
					es_q <= (es_q == sgb_pkg::SLOT_W'(TAPS-1)) ? '0 : es_q + 1'b1;
				end else begin
					ej_q <= ej_q + 1'b1;
				end
			end
		end
	end

	// tail flush after a row's last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_cnt_q <= '0;
			cf_q     <= '0;
			fslot_q  <= '0;
		end else if (row_end) begin
			fl_cnt_q <= sgb_pkg::FLUSH_W'(sgb_pkg::HALF);
			cf_q     <= CW'(rc_q) - CW'(sgb_pkg::HALF - 1);
			fslot_q  <= ws_q;
		end else if (flush_tick) begin
			fl_cnt_q <= fl_cnt_q - 1'b1;
			cf_q     <= cf_q + CW'(1);
		end
	end

	// row window
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k < TAPS - 1) begin : g_mid
			sgb_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(is_pix || flush_tick), .clr(clr_row),
				.d_in(win_d[k+1]), .v_in(win_v[k+1]), .d_out(win_d[k]), .v_out(win_v[k])
			);
		end else begin : g_head
			sgb_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(is_pix || flush_tick), .clr(1'b0),
				.d_in(flush_on ? '0 : pixels.pixel_word), .v_in(!flush_on),
				.d_out(win_d[k]), .v_out(win_v[k])
			);
		end
		assign win_words[k] = win_d[k];
	end

	// control of the horizontal and vertical passes for this cycle
	always_comb begin
		if (flush_on) begin
			hc  = cf_q;
			hwr = flush_tick && !cf_q[CW-1];
		end else begin
			hc  = CW'(rc_q) - CW'(sgb_pkg::HALF);
			hwr = is_pix && (CW'(rc_q) >= CW'(sgb_pkg::HALF));
		end
		hctl_c.wr   = hwr;
		hctl_c.col  = hc[sgb_pkg::COL_W-1:0];
		hctl_c.slot = flush_on ? fslot_q : ws_q;
		hctl_c.copy = (CW'(rad_q) < hc) && (hc + CW'(rad_q) < CW'(w_eff));

		vctl_c.emit = do_emit;
		vctl_c.last = last;
		vctl_c.col  = ej_q;
		vctl_c.slot = es_q;
		vctl_c.copy = (CW'(rad_q) <= CW'(ei_q)) && (CW'(ei_q) + CW'(rad_q) < CW'(h_eff));
		for (int t = 0; t < TAPS; t++) begin
			vctl_c.mask[t] = (CW'(ei_q) + CW'(t) >= CW'(sgb_pkg::HALF)) &&
				(CW'(ei_q) + CW'(t) < CW'(h_eff) + CW'(sgb_pkg::HALF));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= HS; s++) hctl_s[s] <= '0;
			for (int s = 1; s <= VS; s++) vctl_s[s] <= '0;
		end else if (adv) begin
			hctl_s[1] <= hctl_c;
			for (int s = 2; s <= HS; s++) hctl_s[s] <= hctl_s[s-1];
			vctl_s[1] <= vctl_c;
			for (int s = 2; s <= VS; s++) vctl_s[s] <= vctl_s[s-1];
		end
	end

	sgb_tap u_htap (
		.clk(clk), .en(adv), .words(win_words), .mask(win_v),
		.copy(hctl_s[1].copy), .result(hres)
	);

	// line store, one bank per row slot
	for (genvar b = 0; b < TAPS; b++) begin : g_bank
		sgb_line_bank #(
			.DEPTH(sgb_pkg::MAX_WIDTH),
			.WIDTH($bits(sgb_pkg::word_t))
		) u_bank (
			.clk(clk),
			.we(adv && hctl_s[HS].wr && (hctl_s[HS].slot == sgb_pkg::SLOT_W'(b))),
			.waddr(hctl_s[HS].col), .wdata(hres),
			.re(adv), .raddr(vctl_s[5].col), .rdata(rdata[b])
		);
	end

	// rotate bank outputs so lane t holds row i-8+t
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < TAPS; t++) begin
				int v;
				v = int'(vctl_s[6].slot) + t + TAPS - sgb_pkg::HALF;
				if (v >= 2*TAPS) v = v - 2*TAPS;
				else if (v >= TAPS) v = v - TAPS;
				rot_s7[t] <= rdata[sgb_pkg::SLOT_W'(v)];
			end
		end
	end

	sgb_tap u_vtap (
		.clk(clk), .en(adv), .words(rot_s7), .mask(vctl_s[7].mask),
		.copy(vctl_s[7].copy), .result(vres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vctl_s[VS].emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q <= vres;
			out_last_q <= vctl_s[VS].last;
		end
	end

	assign results.valid        = out_v_q;
	assign results.blurred_word = out_word_q;
	assign results.frame_last   = out_last_q;

endmodule

>>> src/sgb_checker.sv
// port checks of the blur top level and the bind that attaches them
module sgb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pix_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input sgb_pkg::word_t       res_word,
	input logic                 res_last,
	input logic                 cfg_ready
);

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word) && $stable(res_last))
		else $error("result changed while stalled");

	// a stalled result blocks new pixels
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pix_ready)
		else $error("pixel taken while result stalled");

	// no result straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

	// register writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register write refused");

endmodule

bind separable_gaussian_blur_17tap sgb_checker u_sgb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pix_ready(pixels.ready),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_word(results.blurred_word),
	.res_last(results.frame_last),
	.cfg_ready(cfg.ready)
);

>>> test/tb_top.sv
// testbench of the separable 17-tap gaussian blur with its own predictor and result check
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF = 4;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 24;
	localparam int BLUR_DIV = 748;
	localparam int TAPS = sgb_pkg::TAPS;
	localparam int HALF = sgb_pkg::HALF;
	localparam int MAX_W = sgb_pkg::MAX_WIDTH;
	localparam int MAX_H = sgb_pkg::MAX_HEIGHT;
	localparam int DIM_W = sgb_pkg::DIM_W;
	localparam int REG_IDX_W = sgb_pkg::REG_IDX_W;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;
	localparam int TAP_TABLE [0:8] = '{80, 77, 70, 59, 46, 34, 24, 15, 9};

	typedef struct {
		sgb_pkg::word_t word;
		logic           last;
	} blur_out_t;

	logic clk;
	logic arst_n;

	sgb_pix_if pix_if ();
	sgb_res_if res_if ();
	sgb_cfg_if cfg_if ();

	separable_gaussian_blur_17tap u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	// predictor state
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [DIM_W-1:0] radius_reg;
	sgb_pkg::word_t row_win [TAPS];
	sgb_pkg::word_t hline [TAPS*MAX_W];
	int pix_seen;
	int pix_sent;

	blur_out_t blur_q [$];
	int err_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	function automatic int eff_dim(logic [DIM_W-1:0] v, int top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	function automatic int tap_of(int t);
		int d;
		d = t - HALF;
		if (d < 0) d = -d;
		if (d > HALF) return 0;
		return TAP_TABLE[d];
	endfunction

	function automatic int line_addr(int r, int c);
		return (r % TAPS) * MAX_W + ((c >= MAX_W) ? MAX_W - 1 : c);
	endfunction

	function automatic logic [3:0][31:0] add_taps(logic [3:0][31:0] acc, sgb_pkg::word_t p,
			int w);
		for (int b = 0; b < 4; b++) acc[b] += p[8*b +: 8] * w;
		return acc;
	endfunction

	function automatic sgb_pkg::word_t divide_sums(logic [3:0][31:0] acc);
		sgb_pkg::word_t v;
		for (int b = 0; b < 4; b++) v[8*b +: 8] = 8'(acc[b] / BLUR_DIV);
		return v;
	endfunction

	function automatic void hblur_col(int r, int c, int q, int w);
		int rad;
		int k;
		int x;
		logic [3:0][31:0] acc;
		sgb_pkg::word_t v;
		rad = radius_reg;
		acc = '0;
		if (c < 0 || c >= w) return;
		if (rad < c && c < w - rad) begin
			k = c - q + TAPS - 1;
			v = (k >= 0 && k < TAPS) ? row_win[k] : '0;
		end else begin
			for (int t = 0; t < TAPS; t++) begin
				x = c - HALF + t;
				k = x - q + TAPS - 1;
				if (x < 0 || x >= w || k < 0 || k >= TAPS) continue;
				acc = add_taps(acc, row_win[k], tap_of(t));
			end
			v = divide_sums(acc);
		end
		hline[line_addr(r, c)] = v;
	endfunction

	function automatic sgb_pkg::word_t vblur_pix(int i, int j, int h);
		int rad;
		int y;
		logic [3:0][31:0] acc;
		rad = radius_reg;
		acc = '0;
		if (rad <= i && i < h - rad) return hline[line_addr(i, j)];
		for (int t = 0; t < TAPS; t++) begin
			y = i - HALF + t;
			if (y < 0 || y >= h) continue;
			acc = add_taps(acc, hline[line_addr(y, j)], tap_of(t));
		end
		return divide_sums(acc);
	endfunction

	function automatic void predict_blur(logic kind, sgb_pkg::word_t pix);
		int w;
		int h;
		int total;
		int r;
		int q;
		int c;
		int i;
		int j;
		int need;
		blur_out_t o;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		total = w * h;
		if (kind == KIND_PIXEL && pix_seen < total) begin
			r = pix_seen / w;
			q = pix_seen % w;
			for (int k = 0; k < TAPS - 1; k++) row_win[k] = row_win[k+1];
			row_win[TAPS-1] = pix;
			if (q == w - 1) begin
				c = (q - HALF < 0) ? 0 : q - HALF;
				while (c <= q) begin
					hblur_col(r, c, q, w);
					c++;
				end
			end else if (q >= HALF) begin
				hblur_col(r, q - HALF, q, w);
			end
			pix_seen++;
		end
		if (pix_sent < total) begin
			i = pix_sent / w;
			j = pix_sent % w;
			need = ((i + HALF < h) ? i + HALF : h - 1) * w + ((j + HALF < w) ? j + HALF : w - 1);
			if (pix_seen > need) begin
				o.word = vblur_pix(i, j, h);
				pix_sent++;
				o.last = (pix_sent == total);
				if (o.last) begin
					pix_seen = 0;
					pix_sent = 0;
				end
				blur_q.push_back(o);
			end
		end
	endfunction

	// sender
	task automatic send_item(logic kind, sgb_pkg::word_t pix);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_if.valid = 1'b0;
			pix_if.kind = 1'($urandom_range(0, 1));
			pix_if.pixel_word = $urandom();
			@(negedge clk);
		end
		pix_if.valid = 1'b1;
		pix_if.kind = kind;
		pix_if.pixel_word = pix;
		do @(posedge clk); while (!pix_if.ready);
		predict_blur(kind, pix);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		pix_if.valid = 1'b0;
		while (blur_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == sgb_pkg::REG_FRAME_WIDTH) width_reg = val;
		else if (idx == sgb_pkg::REG_FRAME_HEIGHT) height_reg = val;
		else if (idx == sgb_pkg::REG_BORDER_RADIUS) radius_reg = val;
		if (idx == sgb_pkg::REG_FRAME_WIDTH || idx == sgb_pkg::REG_FRAME_HEIGHT ||
				idx == sgb_pkg::REG_BORDER_RADIUS) begin
			pix_seen = 0;
			pix_sent = 0;
		end
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_frame(int w, int h, int rad);
		wait_drained();
		write_reg(sgb_pkg::REG_FRAME_WIDTH, DIM_W'(w));
		write_reg(sgb_pkg::REG_FRAME_HEIGHT, DIM_W'(h));
		write_reg(sgb_pkg::REG_BORDER_RADIUS, DIM_W'(rad));
	endtask

	// sends a whole frame, with stray drain requests and dropped pixels in the tail
	task automatic send_frame(int noise_pct, inout int sent);
		int n;
		n = eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_item(KIND_DRAIN, $urandom());
				sent++;
			end
			send_item(KIND_PIXEL, $urandom());
			sent++;
		end
		while (pix_seen != 0) begin
			if ($urandom_range(0, 99) < noise_pct) send_item(KIND_PIXEL, $urandom());
			else send_item(KIND_DRAIN, $urandom());
			sent++;
		end
	endtask

	// sends the start of a frame only
	task automatic send_pixels(int n, inout int sent);
		for (int k = 0; k < n; k++) begin
			send_item(KIND_PIXEL, $urandom());
			sent++;
		end
	endtask

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		blur_out_t exp_o;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (blur_q.size() == 0) begin
				$display("%0t: unexpected result word %h last %b", $time,
					res_if.blurred_word, res_if.frame_last);
				err_count++;
			end else begin
				exp_o = blur_q.pop_front();
				if (res_if.blurred_word !== exp_o.word) begin
					$display("%0t: blurred_word expected %h actual %h", $time,
						exp_o.word, res_if.blurred_word);
					err_count++;
				end
				if (res_if.frame_last !== exp_o.last) begin
					$display("%0t: frame_last expected %b actual %b", $time,
						exp_o.last, res_if.frame_last);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		// whole frame blurred, extreme words, early drain with nothing ready
		set_frame(3, 2, 2048);
		send_item(KIND_DRAIN, '0);
		send_item(KIND_PIXEL, 32'h0000_0000);
		send_item(KIND_PIXEL, 32'hffff_ffff);
		send_item(KIND_PIXEL, 32'ha5a5_5a5a);
		send_item(KIND_PIXEL, 32'hffff_ffff);
		send_item(KIND_PIXEL, 32'h0123_4567);
		send_item(KIND_PIXEL, 32'hfedc_ba98);
		// pixel while draining is dropped
		send_item(KIND_PIXEL, 32'hffff_ffff);
		while (pix_seen != 0) send_item(KIND_DRAIN, '0);
		// interior copied
		set_frame(3, 2, 0);
		for (int k = 0; k < 6; k++) send_item(KIND_PIXEL, (k % 2) ? 32'hffff_ffff : '0);
		while (pix_seen != 0) send_item(KIND_DRAIN, '1);
		// single pixel frame through zero sizes
		set_frame(0, 0, 1);
		send_item(KIND_PIXEL, 32'h8040_20ff);
		send_item(KIND_DRAIN, '0);
	endtask

	task automatic test_config_extremes();
		int sent;
		sent = 0;
		// widest and tallest frames, abandoned after their first outputs
		set_frame(2048, 1, 2048);
		send_pixels(24, sent);
		set_frame(4095, 1, 0);
		send_pixels(24, sent);
		set_frame(1, 2048, 2048);
		send_pixels(24, sent);
		set_frame(1, 4095, 0);
		send_pixels(24, sent);
		wait_drained();
		write_reg(REG_SPARE, '1);
		set_frame(4, 18, 3);
		send_frame(3, sent);
	endtask

	task automatic test_random(int idle_pct, int stall_pct, int items);
		int sent;
		int w;
		int h;
		int rad;
		sent = 0;
		wait_drained();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < items) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
			if (w > 16) h = $urandom_range(1, 2);
			else h = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 4);
			if (h > 16) w = $urandom_range(1, 2);
			rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 10);
			set_frame(w, h, rad);
			send_frame(6, sent);
		end
	endtask

	task automatic test_backpressure();
		int sent;
		sent = 0;
		set_frame(12, 4, 2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_cycles = 400;
		send_frame(0, sent);
	endtask

	initial begin
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.kind = KIND_PIXEL;
		pix_if.pixel_word = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = sgb_pkg::REG_FRAME_WIDTH;
		cfg_if.data = '0;
		width_reg = DIM_W'(640);
		height_reg = DIM_W'(480);
		radius_reg = '0;
		for (int k = 0; k < TAPS; k++) row_win[k] = '0;
		pix_seen = 0;
		pix_sent = 0;
		err_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random(0, 0, 45);
		test_random(47, 0, 45);
		test_random(0, 47, 45);
		test_random(31, 31, 45);
		test_backpressure();
		wait_drained();
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
